### design/mktr_pkg.sv
// shared types, constants and helpers for the multi-key top-k ranker
package mktr_pkg;

    localparam int NAME_W             = 64;
    localparam int SCORE_W            = 16;
    localparam int KEY_W              = 18;
    localparam int LIST_COUNT         = 5;
    localparam int OUT_NAMES          = 4;
    localparam int COUNT_W            = 3;
    localparam int IDX_W              = 3;
    localparam int DEFAULT_TOP_COUNT  = 4;
    localparam int DEFAULT_NAME_CHARS = 8;

    // list numbers
    localparam logic [IDX_W-1:0] LIST_FIRST = IDX_W'(0);
    localparam logic [IDX_W-1:0] LIST_TOTAL = IDX_W'(LIST_COUNT - 1);

    // input item layout
    localparam int S_TDATA_W = NAME_W + 4 * SCORE_W;
    // result item layout, padded to whole bytes
    localparam int M_TDATA_W = ((OUT_NAMES * NAME_W + COUNT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 8;

    // one ranked entry held by a cell
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
    } entry_t;

    // per-cycle control seen by every cell of a list
    typedef struct packed {
        logic ins_en;
        logic clr;
    } cell_ctrl_t;

    // keeps the leading name bytes, drops the rest
    function automatic logic [NAME_W-1:0] name_mask(input int chars);
        logic [NAME_W-1:0] m;
        m = '0;
        for (int b = 0; b < NAME_W / 8; b++) begin
            if (b < chars) begin
                m[NAME_W-1-8*b -: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

### design/mktr_cell.sv
// one slot of a ranked list: holds an entry and shifts it down on insertion
module mktr_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  mktr_pkg::cell_ctrl_t ctrl,
    input  mktr_pkg::entry_t    new_entry,
    input  mktr_pkg::entry_t    prev_entry,
    input  logic                prev_beats,
    output mktr_pkg::entry_t    held_entry,
    output logic                beats
);
    import mktr_pkg::*;

    entry_t held_reg;
    logic   valid_reg;
    logic   keep_held;

    // held entry ranks first on a higher key, or an equal key and a name not larger
    assign keep_held = valid_reg &&
                       ((held_reg.key > new_entry.key) ||
                        ((held_reg.key == new_entry.key) &&
                         (held_reg.name <= new_entry.name)));
    assign beats = !keep_held;

    // payload takes the upper neighbour's entry or the new one
    always_ff @(posedge aclk) begin
        if (ctrl.ins_en && beats) begin
            held_reg <= prev_beats ? prev_entry : new_entry;
        end
    end

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clr) begin
            valid_reg <= 1'b0;
        end else if (ctrl.ins_en && beats) begin
            valid_reg <= prev_beats ? prev_entry.valid : 1'b1;
        end
    end

    always_comb begin
        held_entry       = held_reg;
        held_entry.valid = valid_reg;
    end

endmodule

### design/mktr_list.sv
// one ranked list built as a chain of cells, with its leading names and count
module mktr_list #(
    parameter int TOP_COUNT = mktr_pkg::DEFAULT_TOP_COUNT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  mktr_pkg::cell_ctrl_t                     ctrl,
    input  logic [mktr_pkg::KEY_W-1:0]               key,
    input  logic [mktr_pkg::NAME_W-1:0]              name,
    output logic [mktr_pkg::OUT_NAMES*mktr_pkg::NAME_W-1:0] top_names,
    output logic [mktr_pkg::COUNT_W-1:0]             count
);
    import mktr_pkg::*;

    entry_t               new_entry;
    entry_t               chain [TOP_COUNT];
    logic [TOP_COUNT-1:0] beats;
    logic [OUT_NAMES-1:0] out_valid;

    always_comb begin
        new_entry.valid = 1'b1;
        new_entry.key   = key;
        new_entry.name  = name;
    end

    // the row of cells, each looking at its upper neighbour
    for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
        if (i == 0) begin : g_head
            mktr_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .new_entry  (new_entry),
                .prev_entry (new_entry),
                .prev_beats (1'b0),
                .held_entry (chain[i]),
                .beats      (beats[i])
            );
        end else begin : g_body
            mktr_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .new_entry  (new_entry),
                .prev_entry (chain[i-1]),
                .prev_beats (beats[i-1]),
                .held_entry (chain[i]),
                .beats      (beats[i])
            );
        end
    end

    // leading slots, empty ones read as zero
    for (genvar j = 0; j < OUT_NAMES; j++) begin : g_out
        if (j < TOP_COUNT) begin : g_slot
            assign out_valid[j] = chain[j].valid;
            assign top_names[j*NAME_W +: NAME_W] =
                chain[j].valid ? chain[j].name : '0;
        end else begin : g_none
            assign out_valid[j] = 1'b0;
            assign top_names[j*NAME_W +: NAME_W] = '0;
        end
    end

    // cells fill from the top, so the count is the number of valid slots
    always_comb begin
        count = '0;
        for (int j = 0; j < OUT_NAMES; j++) begin
            count = count + COUNT_W'(out_valid[j]);
        end
    end

endmodule

### design/multi_key_top_k_ranker.sv
// top level of the multi-key top-k ranker: five lists and the result sequencer
//
// Records enter on the s_ channel at one item per cycle; each is inserted in
// the same cycle into five lists (one per score and one on the 18-bit total)
// by a row of compare-and-shift cells per list. The record flagged by s_tlast
// is inserted too, after which the input stalls while the five results are
// shown on the m_ channel in list order, the total last with m_tlast set; the
// lists are cleared as the fifth result is taken, and the next record is
// accepted in the cycle after that.
// Empty slots read as zero names and the count field holds the filled slots.
module multi_key_top_k_ranker #(
    parameter int TOP_COUNT  = mktr_pkg::DEFAULT_TOP_COUNT,
    parameter int NAME_CHARS = mktr_pkg::DEFAULT_NAME_CHARS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // name_key, first_score, second_score, third_score, fourth_score
    input  logic [mktr_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,   // last_item
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // top_name_0, top_name_1, top_name_2, top_name_3, valid_count
    output logic [mktr_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [mktr_pkg::M_TUSER_W-1:0]     m_tuser,   // ranking_index
    output logic                               m_tlast,   // last_of_run
    output logic                               m_tvalid,
    input  logic                               m_tready
);
    import mktr_pkg::*;

    localparam logic [NAME_W-1:0] NameMask = name_mask(NAME_CHARS);

    logic [NAME_W-1:0]  in_name;
    logic [SCORE_W-1:0] in_score [4];
    logic [KEY_W-1:0]   list_key [LIST_COUNT];
    logic [KEY_W-1:0]   total;
    logic               in_accept;
    logic               out_accept;
    logic               emit_reg, emit_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    cell_ctrl_t         ctrl;

    logic [OUT_NAMES*NAME_W-1:0] list_names [LIST_COUNT];
    logic [COUNT_W-1:0]          list_count [LIST_COUNT];

    // unpack the input item
    assign in_name = s_tdata[NAME_W-1:0] & NameMask;
    for (genvar k = 0; k < 4; k++) begin : g_score
        assign in_score[k] = s_tdata[NAME_W + k*SCORE_W +: SCORE_W];
    end
    assign total = KEY_W'(in_score[0]) + KEY_W'(in_score[1]) +
                   KEY_W'(in_score[2]) + KEY_W'(in_score[3]);

    // keys per list
    for (genvar l = 0; l < LIST_COUNT; l++) begin : g_key
        if (l < LIST_COUNT - 1) begin : g_subj
            assign list_key[l] = KEY_W'(in_score[l]);
        end else begin : g_tot
            assign list_key[l] = total;
        end
    end

    // handshakes and cell control
    assign s_tready   = !emit_reg;
    assign in_accept  = s_tvalid && s_tready;
    assign m_tvalid   = emit_reg;
    assign out_accept = m_tvalid && m_tready;
    assign ctrl.ins_en = in_accept;
    assign ctrl.clr    = out_accept && (idx_reg == LIST_TOTAL);

    // the five lists
    for (genvar l = 0; l < LIST_COUNT; l++) begin : g_list
        mktr_list #(
            .TOP_COUNT (TOP_COUNT)
        ) u_list (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .key       (list_key[l]),
            .name      (in_name),
            .top_names (list_names[l]),
            .count     (list_count[l])
        );
    end

    // result sequencer
    always_comb begin
        emit_next = emit_reg;
        idx_next  = idx_reg;
        if (in_accept && s_tlast) begin
            emit_next = 1'b1;
            idx_next  = LIST_FIRST;
        end else if (out_accept) begin
            if (idx_reg == LIST_TOTAL) begin
                emit_next = 1'b0;
                idx_next  = LIST_FIRST;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_reg <= 1'b0;
            idx_reg  <= LIST_FIRST;
        end else begin
            emit_reg <= emit_next;
            idx_reg  <= idx_next;
        end
    end

    // result item from the list being shown
    always_comb begin
        m_tdata = '0;
        for (int l = 0; l < LIST_COUNT; l++) begin
            if (idx_reg == IDX_W'(l)) begin
                m_tdata[OUT_NAMES*NAME_W-1:0] = list_names[l];
                m_tdata[OUT_NAMES*NAME_W +: COUNT_W] = list_count[l];
            end
        end
    end
    assign m_tuser = M_TUSER_W'(idx_reg);
    assign m_tlast = (idx_reg == LIST_TOTAL);

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for the multi-key top-k ranker
module tb_top;
    import mktr_pkg::*;

    localparam int TOP_N         = DEFAULT_TOP_COUNT;
    localparam int RANDOM_ITEMS  = 100;
    localparam int QUIET_FROM    = 80;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int N_DIRECTED    = 18;
    localparam logic [NAME_W-1:0] NAME_KEEP = ~64'h0 << (8 * (8 - DEFAULT_NAME_CHARS));

    // score values that make ties likely
    localparam logic [SCORE_W-1:0] TIE_SCORES [5] = '{16'd0, 16'd1, 16'd100, 16'd32768, 16'd65535};
    localparam logic [NAME_W-1:0] NAME_POOL [4] = '{
        64'h414C_4943_4500_0000,    // ALICE
        64'h424F_4200_0000_0000,    // BOB
        64'h4341_524F_4C00_0000,    // CAROL
        64'h4142_0000_0000_0000     // AB
    };

    // one incoming record
    typedef struct packed {
        logic [NAME_W-1:0]             name;
        logic [3:0][SCORE_W-1:0]       score;
        logic                          last;
    } record_t;

    // one row of the directed table; fixed rows carry a hand-written expectation
    typedef struct packed {
        record_t rec;
        logic    fixed;
    } stim_row_t;

    // one emitted ranking
    typedef struct packed {
        logic [IDX_W-1:0]                  idx;
        logic [OUT_NAMES-1:0][NAME_W-1:0]  names;
        logic [COUNT_W-1:0]                count;
        logic                              last;
    } ranking_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    // predictor copy of the five ranked lists
    logic [KEY_W-1:0]   rank_key  [LIST_COUNT][TOP_N];
    logic [NAME_W-1:0]  rank_name [LIST_COUNT][TOP_N];
    int                 rank_fill [LIST_COUNT];

    ranking_t   pending_rankings [$];
    ranking_t   want_rank;
    ranking_t   got_rank;
    stim_row_t  directed_rows [N_DIRECTED];
    int         error_count = 0;
    int         cycle_count = 0;
    bit         quiet = 1'b0;
    bit         hold_armed = 1'b0;

    multi_key_top_k_ranker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic stim_row_t mk_row(input logic [NAME_W-1:0] nm,
                                         input logic [SCORE_W-1:0] a, b, c, d,
                                         input logic lst, input logic fixed);
        stim_row_t r;
        r.rec.name  = nm;
        r.rec.score = {d, c, b, a};
        r.rec.last  = lst;
        r.fixed     = fixed;
        return r;
    endfunction

    // place one key into a list: higher key first, smaller name first on equal keys
    function automatic void rank_insert(input int l, input logic [KEY_W-1:0] key,
                                        input logic [NAME_W-1:0] nm);
        int pos;
        int tail;
        pos = 0;
        while (pos < rank_fill[l] && (rank_key[l][pos] > key ||
               (rank_key[l][pos] == key && rank_name[l][pos] <= nm)))
            pos++;
        if (pos >= TOP_N)
            return;
        tail = (rank_fill[l] < TOP_N) ? rank_fill[l] : TOP_N - 1;
        for (int i = tail; i > pos; i--) begin
            rank_key[l][i]  = rank_key[l][i-1];
            rank_name[l][i] = rank_name[l][i-1];
        end
        rank_key[l][pos]  = key;
        rank_name[l][pos] = nm;
        if (rank_fill[l] < TOP_N)
            rank_fill[l]++;
    endfunction

    // rank one record; on the last record of a set queue the five rankings and clear
    function automatic void rank_record(input record_t r, input bit keep);
        logic [KEY_W-1:0]  total;
        logic [NAME_W-1:0] nm;
        ranking_t          res;
        total = '0;
        nm = r.name & NAME_KEEP;
        for (int l = 0; l < 4; l++) begin
            total = total + KEY_W'(r.score[l]);
            rank_insert(l, KEY_W'(r.score[l]), nm);
        end
        rank_insert(int'(LIST_TOTAL), total, nm);
        if (!r.last)
            return;
        for (int l = 0; l < LIST_COUNT; l++) begin
            res.idx = IDX_W'(l);
            for (int j = 0; j < OUT_NAMES; j++)
                res.names[j] = (j < rank_fill[l]) ? rank_name[l][j] : '0;
            res.count = COUNT_W'((rank_fill[l] < OUT_NAMES) ? rank_fill[l] : OUT_NAMES);
            res.last  = (l == int'(LIST_TOTAL));
            if (keep)
                pending_rankings.push_back(res);
            rank_fill[l] = 0;
        end
    endfunction

    // offer one record, wait for acceptance, then maybe pause
    task automatic offer_record(input record_t r, input bit fixed);
        ranking_t res;
        s_tdata  <= {r.score, r.name};
        s_tlast  <= r.last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        rank_record(r, !fixed);
        // single-record set: every list holds just that name
        if (fixed) begin
            for (int l = 0; l < LIST_COUNT; l++) begin
                res.idx   = IDX_W'(l);
                res.names = {64'h0, 64'h0, 64'h0, r.name};
                res.count = COUNT_W'(1);
                res.last  = (l == LIST_COUNT - 1);
                pending_rankings.push_back(res);
            end
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        forever begin
            if (hold_armed && m_tvalid) begin
                hold_armed = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // compare each accepted ranking with the oldest one predicted
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_rank.idx   = m_tuser[IDX_W-1:0];
            got_rank.names = m_tdata[OUT_NAMES*NAME_W-1:0];
            got_rank.count = m_tdata[OUT_NAMES*NAME_W +: COUNT_W];
            got_rank.last  = m_tlast;
            if (pending_rankings.size() == 0) begin
                $display("%0t: unexpected ranking, list %0d", $time, got_rank.idx);
                error_count++;
            end else begin
                want_rank = pending_rankings.pop_front();
                if (got_rank.idx !== want_rank.idx) begin
                    $display("%0t: list index expected %0d actual %0d",
                             $time, want_rank.idx, got_rank.idx);
                    error_count++;
                end
                for (int j = 0; j < OUT_NAMES; j++) begin
                    if (got_rank.names[j] !== want_rank.names[j]) begin
                        $display("%0t: list %0d name %0d expected %h actual %h", $time,
                                 want_rank.idx, j, want_rank.names[j], got_rank.names[j]);
                        error_count++;
                    end
                end
                if (got_rank.count !== want_rank.count) begin
                    $display("%0t: list %0d count expected %0d actual %0d", $time,
                             want_rank.idx, want_rank.count, got_rank.count);
                    error_count++;
                end
                if (got_rank.last !== want_rank.last) begin
                    $display("%0t: list %0d last flag expected %b actual %b", $time,
                             want_rank.idx, want_rank.last, got_rank.last);
                    error_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        record_t r;
        int      sent;
        int      run_len;
        int      chars;

        for (int l = 0; l < LIST_COUNT; l++)
            rank_fill[l] = 0;

        directed_rows = '{
            // single-record sets at both extremes
            mk_row(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1),
            mk_row(64'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 1'b1),
            // short set with ties broken by name
            mk_row(64'h414C_4943_4500_0000, 16'd100, 16'd200, 16'd300, 16'd400, 1'b0, 1'b0),
            mk_row(64'h424F_4200_0000_0000, 16'd100, 16'd50, 16'd300, 16'hFFFF, 1'b1, 1'b0),
            // equal key and equal name
            mk_row(64'h4341_524F_4C00_0000, 16'd500, 16'd500, 16'd500, 16'd500, 1'b0, 1'b0),
            mk_row(64'h4341_524F_4C00_0000, 16'd500, 16'd500, 16'd500, 16'd500, 1'b0, 1'b0),
            mk_row(64'h4142_0000_0000_0000, 16'd500, 16'd500, 16'd500, 16'd500, 1'b1, 1'b0),
            // full lists, last record ranked out of some
            mk_row(64'h4E31_0000_0000_0000, 16'd10, 16'd60, 16'd0, 16'hFFFF, 1'b0, 1'b0),
            mk_row(64'h4E32_0000_0000_0000, 16'd20, 16'd50, 16'hFFFF, 16'd0, 1'b0, 1'b0),
            mk_row(64'h4E33_0000_0000_0000, 16'd30, 16'd40, 16'd1, 16'd1, 1'b0, 1'b0),
            mk_row(64'h4E34_0000_0000_0000, 16'd40, 16'd30, 16'd2, 16'd2, 1'b0, 1'b0),
            mk_row(64'h4E35_0000_0000_0000, 16'd50, 16'd20, 16'd3, 16'd3, 1'b0, 1'b0),
            mk_row(64'h4E36_0000_0000_0000, 16'd5, 16'd10, 16'd0, 16'd0, 1'b1, 1'b0),
            // name bit patterns
            mk_row(64'hAAAA_AAAA_AAAA_AAAA, 16'hFFFF, 16'h0, 16'h8000, 16'd1, 1'b0, 1'b0),
            mk_row(64'h5555_5555_5555_5555, 16'h0, 16'hFFFF, 16'h7FFF, 16'd1, 1'b0, 1'b0),
            mk_row(64'h8000_0000_0000_0001, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0),
            mk_row(64'h7FFF_FFFF_FFFF_FFFE, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 1'b0, 1'b0),
            mk_row(64'h0000_0000_0000_0001, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1, 1'b0)
        };

        // reset
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
            offer_record(directed_rows[i].rec, directed_rows[i].fixed);

        // random sets, with one long hold-off on the result side
        hold_armed = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int i = 0; i < run_len; i++) begin
                case ($urandom_range(0, 2))
                    0: r.name = {$urandom, $urandom};
                    1: r.name = NAME_POOL[$urandom_range(0, 3)];
                    default: begin
                        r.name = '0;
                        chars = $urandom_range(1, 8);
                        for (int c = 0; c < chars; c++)
                            r.name[NAME_W-1-8*c -: 8] = 8'($urandom_range(65, 90));
                    end
                endcase
                for (int k = 0; k < 4; k++)
                    r.score[k] = $urandom_range(0, 1) ? SCORE_W'($urandom)
                                                     : TIE_SCORES[$urandom_range(0, 4)];
                r.last = (i == run_len - 1);
                offer_record(r, 1'b0);
                sent++;
                if (sent >= QUIET_FROM)
                    quiet = 1'b1;
            end
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending_rankings.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
